>>> src/saabb_pkg.sv
package saabb_pkg;

    // Shift above the TF fraction bits that gives the saturated time 2.0
    localparam int TIME_SAT_SHIFT = 1;

    typedef struct packed {
        logic neg;   // quotient is negative
        logic inf;   // zero denominator
    } saabb_div_flags_t;

endpackage

>>> src/saabb_div.sv
// Pipelined restoring divider for one time value.
// n = |gap| << 7, d = |den|; q = n/d truncated, TF fraction bits, saturates at 2.0.
// One quotient bit per stage; stall freezes every stage.
module saabb_div
    import saabb_pkg::*;
#(
    parameter int NW = 40,
    parameter int DW = 41,
    parameter int TF = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [TF+1:0] quo
);
    localparam int RW = DW + 1;
    localparam int NS = TF + 1;
    localparam int CW = ((NW > DW) ? NW : DW) + 2;

    logic [NW-1:0] n_reg [NS];
    logic [DW-1:0] d_reg [NS];
    logic [RW-1:0] r_reg [NS];
    logic [TF+1:0] q_reg [NS];
    logic          s_reg [NS];

    // Stage 0: saturation test and integer bit.
    logic [CW-1:0] twod;
    logic [CW-1:0] nwide;
    logic [CW-1:0] dwide;
    assign nwide = CW'(num);
    assign dwide = CW'(den);
    assign twod  = {dwide[CW-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0] <= num;
            d_reg[0] <= den;
            s_reg[0] <= (nwide >= twod);
            if (nwide >= dwide)
            begin
                q_reg[0] <= {{(TF+1){1'b0}}, 1'b1};
                r_reg[0] <= RW'(nwide - dwide);
            end
            else
            begin
                q_reg[0] <= '0;
                r_reg[0] <= RW'(num);
            end
        end
    end

    for (genvar i = 1; i < NS; i++)
    begin : g_stage
        logic [RW-1:0] sh;
        assign sh = {r_reg[i-1][RW-2:0], 1'b0};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[i] <= n_reg[i-1];
                d_reg[i] <= d_reg[i-1];
                s_reg[i] <= s_reg[i-1];
                if (sh >= {1'b0, d_reg[i-1]})
                begin
                    r_reg[i] <= sh - {1'b0, d_reg[i-1]};
                    q_reg[i] <= {q_reg[i-1][TF:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= sh;
                    q_reg[i] <= {q_reg[i-1][TF:0], 1'b0};
                end
            end
        end
    end

    assign quo = s_reg[NS-1] ? (TF+2)'(1) << (TF + TIME_SAT_SHIFT) : q_reg[NS-1];

    logic unused;
    assign unused = rst_n ^ n_reg[NS-1][0];
endmodule

>>> src/saabb_axis.sv
// Per axis front end: doubled gaps, v*frame_time and magnitudes.
module saabb_axis
    import saabb_pkg::*;
#(
    parameter int CB = 24
)(
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [CB-1:0] mp,
    input  logic        [CB-2:0] ms,
    input  logic signed [CB-1:0] tp,
    input  logic        [CB-2:0] ts,
    input  logic signed [CB-1:0] v,
    input  logic        [15:0]   ft,
    output logic        [CB+9:0] n_in,
    output logic        [CB+9:0] n_out,
    output logic        [CB+15:0] dmag,
    output logic                 neg_in,
    output logic                 neg_out,
    output logic                 gin_neg,
    output logic                 inf
);
    localparam int GW = CB + 3;
    localparam int PW = CB + 17;

    logic signed [GW-1:0] gi_reg, go_reg;
    logic signed [PW-1:0] vdt_reg;
    logic signed [GW-1:0] mp2, tp2, msx, tsx, a, b, c, d;

    assign mp2 = GW'(mp) <<< 1;
    assign tp2 = GW'(tp) <<< 1;
    assign msx = GW'({1'b0, ms});
    assign tsx = GW'({1'b0, ts});
    assign a = (tp2 - tsx) - (mp2 + msx);
    assign b = (tp2 + tsx) - (mp2 - msx);
    assign c = b;
    assign d = a;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gi_reg  <= (v > 0) ? a : c;
            go_reg  <= (v > 0) ? b : d;
            vdt_reg <= PW'(v) * PW'($signed({1'b0, ft}));
        end
    end

    logic [GW-1:0] gim, gom;
    logic [PW-1:0] vm;
    assign gim = gi_reg[GW-1] ? GW'(-gi_reg) : GW'(gi_reg);
    assign gom = go_reg[GW-1] ? GW'(-go_reg) : GW'(go_reg);
    assign vm  = vdt_reg[PW-1] ? PW'(-vdt_reg) : PW'(vdt_reg);

    assign n_in    = {gim, 7'b0};
    assign n_out   = {gom, 7'b0};
    assign dmag    = vm[CB+15:0];
    assign neg_in  = (gi_reg != 0) && (gi_reg[GW-1] != vdt_reg[PW-1]);
    assign neg_out = (go_reg != 0) && (go_reg[GW-1] != vdt_reg[PW-1]);
    assign gin_neg = gi_reg[GW-1];
    assign inf     = (vdt_reg == 0);
endmodule

>>> src/swept_aabb_time_of_impact.sv
// Swept box time of impact.
// One box moves by (vx,vy)*frame_time against a static box; the result word
// gives hit, the entry time as Q1.TIME_FRAC_BITS fraction of the frame, and
// the contact normal (-1/0/+1 per axis). No hit gives time 1.0, normal 0.
// Input channel: in_valid/in_stall, one box pair per word. Output channel:
// out_valid/out_stall. frame_time is written by cfg_we/cfg_data; the user
// must do so while idle, the block does not check. Pipe: gap/product stage,
// magnitude register, TIME_FRAC_BITS+1 divider stages, decision stage; the
// divider is fully pipelined, one quotient bit per stage. One word per
// cycle unless a stall on the output freezes the whole pipe; in_stall
// follows out_stall only when the last stage holds a word, so a stall on
// an empty output stage costs nothing, while bubbles further up the pipe
// are kept. Reset clears all valid bits and sets frame_time to 1.0 (256).
module swept_aabb_time_of_impact
    import saabb_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int TIME_FRAC_BITS = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [15:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] mover_x,
    input  logic signed [COORD_BITS-1:0] mover_y,
    input  logic        [COORD_BITS-2:0] mover_w,
    input  logic        [COORD_BITS-2:0] mover_h,
    input  logic signed [COORD_BITS-1:0] mover_vx,
    input  logic signed [COORD_BITS-1:0] mover_vy,
    input  logic signed [COORD_BITS-1:0] target_x,
    input  logic signed [COORD_BITS-1:0] target_y,
    input  logic        [COORD_BITS-2:0] target_w,
    input  logic        [COORD_BITS-2:0] target_h,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [TIME_FRAC_BITS:0]      impact_time,
    output logic signed [1:0]            normal_x,
    output logic signed [1:0]            normal_y
);
    localparam int CB = COORD_BITS;
    localparam int TF = TIME_FRAC_BITS;
    localparam int NW = CB + 10;
    localparam int DW = CB + 16;
    localparam int LAT = TF + 4;   // register stages before output
    localparam int TW = TF + 3;    // signed time, holds +-inf

    logic [15:0] ft_reg;
    logic [LAT-1:0] v_reg;
    logic adv;

    // Pipe moves when the output stage is empty or taken.
    assign adv      = !v_reg[LAT-1] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg <= 16'd256;
            v_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                ft_reg <= cfg_data;
            if (adv)
                v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    // Per axis front end
    logic [NW-1:0] xni, xno, yni, yno;
    logic [DW-1:0] xd, yd;
    logic xnegi, xnego, xgn, xinf, ynegi, ynego, ygn, yinf;

    saabb_axis #(.CB(CB)) u_ax (
        .clk(clk), .adv(adv), .mp(mover_x), .ms(mover_w), .tp(target_x),
        .ts(target_w), .v(mover_vx), .ft(ft_reg), .n_in(xni), .n_out(xno),
        .dmag(xd), .neg_in(xnegi), .neg_out(xnego), .gin_neg(xgn), .inf(xinf));
    saabb_axis #(.CB(CB)) u_ay (
        .clk(clk), .adv(adv), .mp(mover_y), .ms(mover_h), .tp(target_y),
        .ts(target_h), .v(mover_vy), .ft(ft_reg), .n_in(yni), .n_out(yno),
        .dmag(yd), .neg_in(ynegi), .neg_out(ynego), .gin_neg(ygn), .inf(yinf));

    // Magnitude register before the divider
    logic [NW-1:0] xni_reg, xno_reg, yni_reg, yno_reg;
    logic [DW-1:0] xd_reg, yd_reg;
    logic [3:0] fl_reg;   // sign flags entry/exit per axis
    logic [1:0] gn_reg, inf_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xni_reg <= xni; xno_reg <= xno; yni_reg <= yni; yno_reg <= yno;
            xd_reg  <= xd;  yd_reg  <= yd;
            fl_reg  <= {xnegi, xnego, ynegi, ynego};
            gn_reg  <= {xgn, ygn};
            inf_reg <= {xinf, yinf};
        end
    end

    // Side flags delayed alongside the divider
    saabb_div_flags_t fx_in [TF+1], fx_out [TF+1], fy_in [TF+1], fy_out [TF+1];
    logic [1:0] gn_d [TF+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_in[0]  <= '{neg: fl_reg[3], inf: inf_reg[1]};
            fx_out[0] <= '{neg: fl_reg[2], inf: inf_reg[1]};
            fy_in[0]  <= '{neg: fl_reg[1], inf: inf_reg[0]};
            fy_out[0] <= '{neg: fl_reg[0], inf: inf_reg[0]};
            gn_d[0]   <= gn_reg;
            for (int i = 1; i <= TF; i++)
            begin
                fx_in[i] <= fx_in[i-1]; fx_out[i] <= fx_out[i-1];
                fy_in[i] <= fy_in[i-1]; fy_out[i] <= fy_out[i-1];
                gn_d[i]  <= gn_d[i-1];
            end
        end
    end

    logic [TF+1:0] qxi, qxo, qyi, qyo;
    saabb_div #(.NW(NW), .DW(DW), .TF(TF)) u_dxi (.clk(clk), .rst_n(rst_n), .adv(adv),
        .num(xni_reg), .den(xd_reg), .quo(qxi));
    saabb_div #(.NW(NW), .DW(DW), .TF(TF)) u_dxo (.clk(clk), .rst_n(rst_n), .adv(adv),
        .num(xno_reg), .den(xd_reg), .quo(qxo));
    saabb_div #(.NW(NW), .DW(DW), .TF(TF)) u_dyi (.clk(clk), .rst_n(rst_n), .adv(adv),
        .num(yni_reg), .den(yd_reg), .quo(qyi));
    saabb_div #(.NW(NW), .DW(DW), .TF(TF)) u_dyo (.clk(clk), .rst_n(rst_n), .adv(adv),
        .num(yno_reg), .den(yd_reg), .quo(qyo));

    // Signed times; infinity is one past saturation
    localparam logic signed [TW-1:0] T_INF = TW'((1 << (TF + 1)) + 1);
    localparam logic signed [TW-1:0] T_ONE = TW'(1 << TF);

    function automatic logic signed [TW-1:0] to_t(input logic [TF+1:0] q,
                                                 input logic neg);
        logic signed [TW-1:0] m;
        m = $signed({1'b0, q});
        return neg ? -m : m;
    endfunction

    logic signed [TW-1:0] xe, xx, ye, yx, ent, lv;
    always_comb
    begin
        xe = fx_in[TF].inf  ? -T_INF : to_t(qxi, fx_in[TF].neg);
        xx = fx_out[TF].inf ?  T_INF : to_t(qxo, fx_out[TF].neg);
        ye = fy_in[TF].inf  ? -T_INF : to_t(qyi, fy_in[TF].neg);
        yx = fy_out[TF].inf ?  T_INF : to_t(qyo, fy_out[TF].neg);
        ent = (xe > ye) ? xe : ye;
        lv  = (xx < yx) ? xx : yx;
    end

    logic miss;
    assign miss = (ent > lv) || (xe < 0 && ye < 0) || (xe > T_ONE) || (ye > T_ONE);

    logic hit_reg;
    logic [TF:0] t_reg;
    logic signed [1:0] nx_reg, ny_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= !miss;
            t_reg   <= miss ? T_ONE[TF:0] : ent[TF:0];
            nx_reg  <= (!miss && xe > ye) ? (gn_d[TF][1] ? 2'sd1 : -2'sd1) : 2'sd0;
            ny_reg  <= (!miss && !(xe > ye)) ? (gn_d[TF][0] ? 2'sd1 : -2'sd1) : 2'sd0;
        end
    end

    assign out_valid   = v_reg[LAT-1];
    assign hit         = hit_reg;
    assign impact_time = t_reg;
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
endmodule

>>> src/saabb_check.sv
module saabb_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [16:0] impact_time,
    input logic [1:0]  normal_x,
    input logic [1:0]  normal_y
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(impact_time))
        else $error("stalled word changed");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> impact_time == 17'h10000 && normal_x == 0 && normal_y == 0)
        else $error("miss word malformed");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> $countones({normal_x != 0, normal_y != 0}) == 1)
        else $error("hit without single normal");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
endmodule

bind swept_aabb_time_of_impact saabb_check u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
    .impact_time(impact_time), .normal_x(normal_x), .normal_y(normal_y));

>>> tb/sv/tb.sv
module tb;

    // Box coordinates are Q16.8: 24 bits signed for positions and speeds, 23 bits
    // unsigned for sizes. Times come back as Q1.16.
    localparam int CB = 24;
    localparam int TF = 16;
    localparam int LATENCY = TF + 4;
    localparam longint T_ONE = 64'sd1 << TF;
    localparam longint T_SAT = 64'sd1 << (TF + 1);
    localparam longint T_INF = T_SAT + 1;

    // One box pair as it goes into the block.
    typedef struct {
        logic signed [CB-1:0] mx, my, vx, vy, tx, ty;
        logic        [CB-2:0] mw, mh, tw, th;
    } box_pair_t;

    // One collision answer as it comes out of the block.
    typedef struct {
        logic          hit;
        logic [TF:0]   t;
        logic [1:0]    nx, ny;
    } impact_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] mover_x = '0, mover_y = '0, mover_vx = '0, mover_vy = '0;
    logic signed [CB-1:0] target_x = '0, target_y = '0;
    logic [CB-2:0] mover_w = '0, mover_h = '0, target_w = '0, target_h = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [TF:0] impact_time;
    logic signed [1:0] normal_x, normal_y;

    swept_aabb_time_of_impact u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mover_x(mover_x), .mover_y(mover_y), .mover_w(mover_w), .mover_h(mover_h),
        .mover_vx(mover_vx), .mover_vy(mover_vy),
        .target_x(target_x), .target_y(target_y),
        .target_w(target_w), .target_h(target_h),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
        .impact_time(impact_time), .normal_x(normal_x), .normal_y(normal_y)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the frame time register.
    logic [15:0] frame_dt;
    impact_t     pending_impacts[$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_seen = 0;
    int          hits_seen = 0;
    int          rx_mode = 0;

    // Gap (9 fraction bits) over v*dt (16 fraction bits), truncated to TF bits,
    // saturating to +-2.0 once the magnitude reaches 2.0.
    function automatic longint toi_divide(longint gap, longint den);
        logic    neg;
        longint  n, d, q, r;
        neg = (gap != 0) && ((gap < 0) != (den < 0));
        n = (gap < 0 ? -gap : gap) << 7;
        d = den < 0 ? -den : den;
        if (n >= 2 * d)
        begin
            q = T_SAT;
        end
        else
        begin
            q = (n >= d) ? 1 : 0;
            r = (n >= d) ? n - d : n;
            for (int i = 0; i < TF; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
        end
        return neg ? -q : q;
    endfunction

    // Entry/exit times on one axis; zero velocity*dt means minus/plus infinity.
    function automatic void axis_sweep(input longint mp, ms, tp, ts, v,
                                       output longint t_in, t_out, g_in);
        longint g_out, vdt;
        if (v > 0)
        begin
            g_in = (2 * tp - ts) - (2 * mp + ms);
            g_out = (2 * tp + ts) - (2 * mp - ms);
        end
        else
        begin
            g_in = (2 * tp + ts) - (2 * mp - ms);
            g_out = (2 * tp - ts) - (2 * mp + ms);
        end
        vdt = v * longint'(frame_dt);
        if (vdt == 0)
        begin
            t_in = -T_INF;
            t_out = T_INF;
        end
        else
        begin
            t_in = toi_divide(g_in, vdt);
            t_out = toi_divide(g_out, vdt);
        end
    endfunction

    function automatic impact_t predict_impact(box_pair_t b);
        impact_t r;
        longint xe, xx, xg, ye, yx, yg, t_enter, t_leave;
        axis_sweep(longint'(b.mx), longint'(b.mw), longint'(b.tx), longint'(b.tw),
                   longint'(b.vx), xe, xx, xg);
        axis_sweep(longint'(b.my), longint'(b.mh), longint'(b.ty), longint'(b.th),
                   longint'(b.vy), ye, yx, yg);
        t_enter = xe > ye ? xe : ye;
        t_leave = xx < yx ? xx : yx;
        r.nx = 2'b00;
        r.ny = 2'b00;
        if (t_enter > t_leave || (xe < 0 && ye < 0) || xe > T_ONE || ye > T_ONE)
        begin
            r.hit = 1'b0;
            r.t = T_ONE[TF:0];
        end
        else
        begin
            r.hit = 1'b1;
            r.t = t_enter[TF:0];
            if (xe > ye)
                r.nx = (xg < 0) ? 2'b01 : 2'b11;
            else
                r.ny = (yg < 0) ? 2'b01 : 2'b11;
        end
        return r;
    endfunction

    // Random gap: mostly zero or short, now and then long.
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic signed [CB-1:0] rnd_coord(int span);
        int s;
        s = $urandom_range(2 * span) - span;
        return CB'(s);
    endfunction

    // Random pair, mostly boxes that are near each other and moving toward
    // each other so that hits are common; the rest is full-range noise.
    function automatic box_pair_t rnd_pair();
        box_pair_t b;
        int k;
        k = $urandom_range(9);
        if (k < 2)
        begin
            b.mx = CB'($urandom); b.my = CB'($urandom);
            b.vx = CB'($urandom); b.vy = CB'($urandom);
            b.tx = CB'($urandom); b.ty = CB'($urandom);
            b.mw = (CB-1)'($urandom); b.mh = (CB-1)'($urandom);
            b.tw = (CB-1)'($urandom); b.th = (CB-1)'($urandom);
        end
        else
        begin
            b.mx = rnd_coord(8000); b.my = rnd_coord(8000);
            b.tx = rnd_coord(8000); b.ty = rnd_coord(8000);
            b.mw = (CB-1)'($urandom_range(4000)); b.mh = (CB-1)'($urandom_range(4000));
            b.tw = (CB-1)'($urandom_range(4000)); b.th = (CB-1)'($urandom_range(4000));
            b.vx = (b.tx - b.mx) + rnd_coord(3000);
            b.vy = (b.ty - b.my) + rnd_coord(3000);
            if ($urandom_range(9) == 0) b.vx = '0;
            if ($urandom_range(9) == 0) b.vy = '0;
        end
        return b;
    endfunction

    // Valid stays high between back to back words; it drops only for a gap.
    task automatic send_word(box_pair_t b, impact_t want, bit typed);
        int gap;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mover_x <= b.mx; mover_y <= b.my; mover_w <= b.mw; mover_h <= b.mh;
        mover_vx <= b.vx; mover_vy <= b.vy;
        target_x <= b.tx; target_y <= b.ty; target_w <= b.tw; target_h <= b.th;
        if (typed)
            pending_impacts.push_back(want);
        else
            pending_impacts.push_back(predict_impact(b));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Write frame time only with the pipe drained and empty.
    task automatic set_frame_dt(logic [15:0] v);
        in_valid <= 1'b0;
        while (pending_impacts.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_dt = v;
    endtask

    // Receiver: random stalls, with stretches of none (rx_mode 0).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_mode == 0)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < rx_mode);
            if ($urandom_range(199) == 0)
                rx_mode <= ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 10);
        end
    end

    // Result checker, sampled at the edge that accepts the word.
    always @(posedge clk)
    begin
        impact_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_impacts.size() == 0)
            begin
                $display("%0t: unexpected result word hit=%0d t=%0d", $time, hit, impact_time);
                errors++;
            end
            else
            begin
                want = pending_impacts.pop_front();
                if (hit) hits_seen++;
                if (hit !== want.hit || impact_time !== want.t ||
                    normal_x !== want.nx || normal_y !== want.ny)
                begin
                    $display({"%0t: mismatch expected hit=%0d t=%0d n=(%0d,%0d)",
                              " got hit=%0d t=%0d n=(%0d,%0d)"},
                             $time, want.hit, want.t, $signed(want.nx), $signed(want.ny),
                             hit, impact_time, normal_x, normal_y);
                    errors++;
                end
            end
        end
    end

    // Directed table: extremes, zero speeds, touching at 1.0, both normals.
    typedef struct {
        box_pair_t b;
        bit        typed;
        impact_t   r;
    } toi_row_t;

    toi_row_t sweep_table[$];

    function automatic box_pair_t mk(int mx, my, mw, mh, vx, vy, tx, ty, tw, th);
        box_pair_t b;
        b.mx = CB'(mx); b.my = CB'(my); b.mw = (CB-1)'(mw); b.mh = (CB-1)'(mh);
        b.vx = CB'(vx); b.vy = CB'(vy);
        b.tx = CB'(tx); b.ty = CB'(ty); b.tw = (CB-1)'(tw); b.th = (CB-1)'(th);
        return b;
    endfunction

    function automatic impact_t res(logic h, int t, logic [1:0] nx, ny);
        impact_t r;
        r.hit = h; r.t = (TF+1)'(t); r.nx = nx; r.ny = ny;
        return r;
    endfunction

    task automatic add_row(box_pair_t b, bit typed, impact_t r);
        toi_row_t row;
        row.b = b; row.typed = typed; row.r = r;
        sweep_table.push_back(row);
    endtask

    initial
    begin
        box_pair_t b;
        impact_t   none;
        none = res(1'b0, 32'h10000, 2'b00, 2'b00);
        frame_dt = 16'd256;
        // zero velocity both axes: no hit
        add_row(mk(0, 0, 256, 256, 0, 0, 0, 0, 256, 256), 1'b1, none);
        // moving right by 2.0, gap 2.0 => entry at 1.0 on x, normal -1
        add_row(mk(0, 0, 256, 256, 512, 0, 768, 0, 256, 256), 1'b0, none);
        // moving left
        add_row(mk(768, 0, 256, 256, -512, 0, 0, 0, 256, 256), 1'b0, none);
        // moving up / down
        add_row(mk(0, 0, 256, 256, 0, 512, 0, 768, 256, 256), 1'b0, none);
        add_row(mk(0, 768, 256, 256, 0, -512, 0, 0, 256, 256), 1'b0, none);
        // contact exactly at 1.0
        add_row(mk(0, 0, 256, 256, 256, 0, 512, 0, 256, 256), 1'b0, none);
        // moving away: no hit
        add_row(mk(0, 0, 256, 256, -256, 0, 1024, 0, 256, 256), 1'b1, none);
        // diagonal, both axes
        add_row(mk(0, 0, 256, 256, 512, 512, 768, 700, 256, 256), 1'b0, none);
        // extremes of every field
        add_row(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                   8388607, 8388607, 8388607, 8388607), 1'b0, none);
        add_row(mk(8388607, 8388607, 0, 0, -8388608, -8388608,
                   -8388608, -8388608, 0, 0), 1'b0, none);
        add_row(mk(-1, -1, 8388607, 0, 1, -1, 0, 0, 0, 8388607), 1'b0, none);
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none);
        // already overlapping, moving
        add_row(mk(0, 0, 1024, 1024, 256, 256, 100, 100, 1024, 1024), 1'b0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (sweep_table[i])
            send_word(sweep_table[i].b, sweep_table[i].r, sweep_table[i].typed);

        // Sweep frame time through extremes and typical values.
        foreach (sweep_table[i])
        begin
            if (i == 0) set_frame_dt(16'd0);
            send_word(sweep_table[i].b, none, 1'b0);
        end
        set_frame_dt(16'hFFFF);
        foreach (sweep_table[i]) send_word(sweep_table[i].b, none, 1'b0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_frame_dt(16'd256);
                1: set_frame_dt(16'd1);
                2: set_frame_dt(16'hFFFF);
                default: set_frame_dt(16'($urandom));
            endcase
            for (int n = 0; n < 150; n++)
            begin
                b = rnd_pair();
                send_word(b, none, 1'b0);
                // Hold off the sender now and then until the pipe drains.
                if (n == 75)
                begin
                    in_valid <= 1'b0;
                    while (pending_impacts.size() != 0) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_impacts.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        $display("Sent %0d box pairs over 9 frame time settings, %0d results, %0d hits.",
                 words_sent, words_seen, hits_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
